// ----- rtl/core/cwb_pkg.sv -----
// Package for the coalescing write buffer: opcodes, item classes, queue item
// and threshold types, and the constants of the watermark arithmetic.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package cwb_pkg;

  localparam int BP_W      = 6;   // buffer_pages register width
  localparam int WP_W      = 7;   // watermark_percent register width
  localparam int CFG_W     = 7;   // configuration write data width
  localparam int CFG_IDX_W = 2;
  localparam int OPC_W     = 2;
  localparam int PAGE_W    = 32;

  localparam int PCT_MAX  = 100;
  localparam int PROD_W   = 13;   // 63 * 100 fits
  // floor(x / 100) = (x * 5243) >> 19 for every x below 2^13.
  localparam int RECIP    = 5243;
  localparam int RECIP_SH = 19;
  localparam int RPROD_W  = 2 * PROD_W;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [1:0] {
    OPC_WRITE   = 2'd0,
    OPC_READ    = 2'd1,
    OPC_DISCARD = 2'd2,
    OPC_FLUSH   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_BUFFER_PAGES = 2'd0,
    CFG_WATERMARK    = 2'd1,
    CFG_CACHE_EN     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CLS_WR_BUF,
    CLS_WR_DIRECT,
    CLS_WR_DRAIN,
    CLS_READ,
    CLS_DISCARD,
    CLS_FLUSH
  } cls_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVICT,
    ST_DONE
  } state_e;

  typedef struct packed {
    cls_e                cls;
    logic [PAGE_W-1:0]   page;
  } item_t;

  typedef struct packed {
    logic [BP_W-1:0] wm;
    logic [BP_W-1:0] batch;
  } thresh_t;

endpackage

`default_nettype wire

// ----- rtl/core/cwb_if.sv -----
// Request channels of the coalescing write buffer: input and result.
// Depends on cwb_pkg for the field widths.
`default_nettype none

interface cwb_in_if;
  logic                       valid;
  logic                       ready;
  logic [cwb_pkg::OPC_W-1:0]  opcode;
  logic [cwb_pkg::PAGE_W-1:0] page_number;
  logic                       force_unit_access;

  modport source (output valid, opcode, page_number, force_unit_access, input ready);
  modport sink (input valid, opcode, page_number, force_unit_access, output ready);
endinterface

interface cwb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [cwb_pkg::PAGE_W-1:0] out_page;
  logic                       hit;
  logic                       direct;
  logic                       last;

  modport source (output valid, kind, out_page, hit, direct, last, input ready);
  modport sink (input valid, kind, out_page, hit, direct, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cwb_front.sv -----
// Front end: configuration registers, watermark and batch computation, and
// classification of incoming requests. Depends on cwb_pkg and cwb_if.
`default_nettype none

module cwb_front #(
  parameter int DEPTH     = 32,
  parameter int PAGE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  cwb_in_if.sink                             in_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [cwb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cwb_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output cwb_pkg::item_t                     item_o,
  output cwb_pkg::thresh_t                   thresh_o
);

  localparam int KEEP = (PAGE_BITS < cwb_pkg::PAGE_W) ? PAGE_BITS : cwb_pkg::PAGE_W;

  logic [cwb_pkg::BP_W-1:0]    buf_q;
  logic [cwb_pkg::WP_W-1:0]    pct_q;
  logic                        en_q;
  logic [cwb_pkg::PROD_W-1:0]  prod_q, prod_d;
  cwb_pkg::thresh_t            thresh_q, thresh_d;
  logic [cwb_pkg::BP_W-1:0]    size6;
  logic [cwb_pkg::WP_W-1:0]    pct7;
  logic [cwb_pkg::RPROD_W-1:0] scaled;
  logic [cwb_pkg::BP_W-1:0]    wm_raw;
  logic                        enabled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      pct_q <= cwb_pkg::WP_W'(90);
      en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cwb_pkg::cfg_idx_e'(cfg_idx_i))
        cwb_pkg::CFG_BUFFER_PAGES: buf_q <= cfg_data_i[cwb_pkg::BP_W-1:0];
        cwb_pkg::CFG_WATERMARK:    pct_q <= cfg_data_i[cwb_pkg::WP_W-1:0];
        cwb_pkg::CFG_CACHE_EN:     en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size6 = (buf_q > cwb_pkg::BP_W'(DEPTH)) ? cwb_pkg::BP_W'(DEPTH) : buf_q;
    pct7  = (pct_q > cwb_pkg::WP_W'(cwb_pkg::PCT_MAX)) ?
            cwb_pkg::WP_W'(cwb_pkg::PCT_MAX) : pct_q;
    prod_d = cwb_pkg::PROD_W'(size6) * cwb_pkg::PROD_W'(pct7);
    // Division by 100 as a multiply by its reciprocal on the registered product.
    scaled = cwb_pkg::RPROD_W'(prod_q) * cwb_pkg::RPROD_W'(cwb_pkg::RECIP);
    wm_raw = cwb_pkg::BP_W'(scaled >> cwb_pkg::RECIP_SH);
    thresh_d.wm    = (wm_raw == '0) ? cwb_pkg::BP_W'(1) : wm_raw;
    thresh_d.batch = (size6 > thresh_d.wm) ? size6 - thresh_d.wm : cwb_pkg::BP_W'(1);
    enabled = (size6 != '0) && en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q   <= '0;
      thresh_q <= '0;
    end else begin
      prod_q   <= prod_d;
      thresh_q <= thresh_d;
    end
  end

  assign thresh_o = thresh_q;

  always_comb begin
    item_o.page = cwb_pkg::PAGE_W'(in_i.page_number[KEEP-1:0]);
    case (cwb_pkg::opcode_e'(in_i.opcode))
      cwb_pkg::OPC_WRITE: begin
        if (!enabled) begin
          item_o.cls = cwb_pkg::CLS_WR_DRAIN;
        end else if (in_i.force_unit_access) begin
          item_o.cls = cwb_pkg::CLS_WR_DIRECT;
        end else begin
          item_o.cls = cwb_pkg::CLS_WR_BUF;
        end
      end
      cwb_pkg::OPC_READ:    item_o.cls = cwb_pkg::CLS_READ;
      cwb_pkg::OPC_DISCARD: item_o.cls = cwb_pkg::CLS_DISCARD;
      cwb_pkg::OPC_FLUSH:   item_o.cls = cwb_pkg::CLS_FLUSH;
      default:              item_o.cls = cwb_pkg::CLS_FLUSH;
    endcase
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

endmodule

`default_nettype wire

// ----- rtl/core/cwb_queue.sv -----
// Two-entry queue of classified requests between front and back end.
// Depends on cwb_pkg.
`default_nettype none

module cwb_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cwb_pkg::item_t  item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output cwb_pkg::item_t       item_o,
  input  wire logic            pop_i
);

  cwb_pkg::item_t slot_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_q];

endmodule

`default_nettype wire

// ----- rtl/core/cwb_back.sv -----
// Back end: the recency-ordered page list, the sequencer that looks up,
// evicts, drains and completes requests, and the result register.
// Depends on cwb_pkg and cwb_if.
`default_nettype none

module cwb_back #(
  parameter int DEPTH     = 32,
  parameter int PAGE_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire cwb_pkg::item_t   item_i,
  output logic                  pop_o,
  input  wire cwb_pkg::thresh_t thresh_i,
  cwb_out_if.source             out_o
);

  localparam int KEEP = (PAGE_BITS < cwb_pkg::PAGE_W) ? PAGE_BITS : cwb_pkg::PAGE_W;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = $clog2(DEPTH);

  // Entry 0 is the least recently written page.
  logic [KEEP-1:0]     entry_q [DEPTH];
  logic [CW-1:0]       fill_q, fill_d;
  cwb_pkg::state_e     state_q, state_d;
  cwb_pkg::item_t      cur_q;
  logic [cwb_pkg::BP_W-1:0] cnt_q, cnt_d;
  logic                app_q, app_d, drain_q, drain_d;
  logic                dhit_q, dhit_d, ddir_q, ddir_d;

  logic                out_vld_q, out_vld_d;
  logic                okind_q, okind_d, ohit_q, ohit_d, odir_q, odir_d, olast_q, olast_d;
  logic [cwb_pkg::PAGE_W-1:0] opage_q, opage_d;

  logic [DEPTH-1:0]    match;
  logic                hit;
  logic [PW-1:0]       pos;
  logic                out_free;
  logic                sh_en, wr_en;
  logic [PW-1:0]       sh_pos, wr_pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CW'(i) < fill_q) && (entry_q[i] == cur_q.page[KEEP-1:0]);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) pos = PW'(i);
    end
    hit = |match;
  end

  assign out_free = !out_vld_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    app_d   = app_q;
    drain_d = drain_q;
    dhit_d  = dhit_q;
    ddir_d  = ddir_q;
    pop_o   = 1'b0;
    sh_en   = 1'b0;
    sh_pos  = '0;
    wr_en   = 1'b0;
    wr_pos  = '0;
    out_vld_d = out_vld_q && !out_o.ready;
    okind_d = okind_q;
    opage_d = opage_q;
    ohit_d  = ohit_q;
    odir_d  = odir_q;
    olast_d = olast_q;

    case (state_q)
      cwb_pkg::ST_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          state_d = cwb_pkg::ST_LOOK;
        end
      end

      cwb_pkg::ST_LOOK: begin
        app_d   = 1'b0;
        drain_d = 1'b0;
        dhit_d  = 1'b0;
        ddir_d  = 1'b0;
        state_d = cwb_pkg::ST_DONE;
        case (cur_q.cls)
          cwb_pkg::CLS_WR_BUF: begin
            if (hit) begin
              // Coalesced write: the page moves to the tail of the list.
              sh_en  = 1'b1;
              sh_pos = pos;
              wr_en  = 1'b1;
              wr_pos = PW'(fill_q - CW'(1));
              dhit_d = 1'b1;
            end else begin
              app_d = 1'b1;
              if (cwb_pkg::BP_W'(fill_q) >= thresh_i.wm) begin
                cnt_d   = thresh_i.batch;
                state_d = cwb_pkg::ST_EVICT;
              end
            end
          end
          cwb_pkg::CLS_WR_DIRECT, cwb_pkg::CLS_WR_DRAIN: begin
            ddir_d = 1'b1;
            if (hit) begin
              sh_en  = 1'b1;
              sh_pos = pos;
              fill_d = fill_q - CW'(1);
            end
            if (cur_q.cls == cwb_pkg::CLS_WR_DRAIN) begin
              drain_d = 1'b1;
              state_d = cwb_pkg::ST_EVICT;
            end
          end
          cwb_pkg::CLS_READ: begin
            dhit_d = hit;
          end
          cwb_pkg::CLS_DISCARD: begin
            dhit_d = hit;
            if (hit) begin
              sh_en  = 1'b1;
              sh_pos = pos;
              fill_d = fill_q - CW'(1);
            end
          end
          cwb_pkg::CLS_FLUSH: begin
            drain_d = 1'b1;
            state_d = cwb_pkg::ST_EVICT;
          end
          default: ;
        endcase
      end

      cwb_pkg::ST_EVICT: begin
        if (fill_q == '0) begin
          state_d = cwb_pkg::ST_DONE;
        end else if (out_free) begin
          out_vld_d = 1'b1;
          okind_d   = cwb_pkg::KIND_EVICT;
          opage_d   = cwb_pkg::PAGE_W'(entry_q[0]);
          ohit_d    = 1'b0;
          odir_d    = 1'b0;
          olast_d   = 1'b0;
          sh_en     = 1'b1;
          sh_pos    = '0;
          fill_d    = fill_q - CW'(1);
          cnt_d     = cnt_q - cwb_pkg::BP_W'(1);
          if (drain_q ? (fill_q == CW'(1)) : (cnt_q == cwb_pkg::BP_W'(1))) begin
            state_d = cwb_pkg::ST_DONE;
          end
        end
      end

      cwb_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          okind_d   = cwb_pkg::KIND_DONE;
          opage_d   = (cur_q.cls == cwb_pkg::CLS_FLUSH) ? '0 : cur_q.page;
          ohit_d    = dhit_q;
          odir_d    = ddir_q;
          olast_d   = 1'b1;
          if (app_q) begin
            wr_en  = 1'b1;
            wr_pos = PW'(fill_q);
            fill_d = fill_q + CW'(1);
          end
          state_d = cwb_pkg::ST_IDLE;
        end
      end

      default: state_d = cwb_pkg::ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    if (g < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (wr_en && wr_pos == PW'(g)) begin
          entry_q[g] <= cur_q.page[KEEP-1:0];
        end else if (sh_en && PW'(g) >= sh_pos) begin
          entry_q[g] <= entry_q[g+1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (wr_en && wr_pos == PW'(g)) begin
          entry_q[g] <= cur_q.page[KEEP-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
    cnt_q   <= cnt_d;
    app_q   <= app_d;
    drain_q <= drain_d;
    dhit_q  <= dhit_d;
    ddir_q  <= ddir_d;
    okind_q <= okind_d;
    opage_q <= opage_d;
    ohit_q  <= ohit_d;
    odir_q  <= odir_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cwb_pkg::ST_IDLE;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.kind     = okind_q;
  assign out_o.out_page = opage_q;
  assign out_o.hit      = ohit_q;
  assign out_o.direct   = odir_q;
  assign out_o.last     = olast_q;

endmodule

`default_nettype wire

// ----- rtl/core/coalescing_write_buffer_unit.sv -----
// Coalescing write buffer: front end, request queue and back end.
// Requests pass through the queue and the sequencer's idle, look-up and done
// states; the eviction state between sends out pages one at a time and also
// runs with no output when a flush or drain finds the list empty or a batch
// runs out of pages; result stalls hold it. The sequencer takes no new
// request before the last completes. Reset empties the list, sets registers
// to 0, 90 and 1. Depends on cwb_pkg, cwb_if, cwb_front, cwb_queue, cwb_back.
`default_nettype none

module coalescing_write_buffer_unit #(
  parameter int DEPTH     = 32,
  parameter int PAGE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  cwb_in_if.sink                             in_i,
  cwb_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cwb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cwb_pkg::CFG_W-1:0]     cfg_data_i
);

  logic             push, full, q_valid, pop;
  cwb_pkg::item_t   push_item, q_item;
  cwb_pkg::thresh_t thresh;

  cwb_front #(.DEPTH(DEPTH), .PAGE_BITS(PAGE_BITS)) u_front (
    .clk_i, .rst_ni, .in_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .full_i(full), .push_o(push), .item_o(push_item), .thresh_o(thresh)
  );

  cwb_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .full_o(full),
    .valid_o(q_valid), .item_o(q_item), .pop_i(pop)
  );

  cwb_back #(.DEPTH(DEPTH), .PAGE_BITS(PAGE_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(q_item), .pop_o(pop),
    .thresh_i(thresh), .out_o
  );

endmodule

`default_nettype wire

// ----- tb/tb_coalescing_write_buffer_unit.sv -----
// Self-checking testbench for the coalescing write buffer unit.
// Table rows check typed results; directed and random traffic is checked
// against a local page-list model. Depends on cwb_pkg, cwb_if and the block itself.
`timescale 1ns / 1ps

module tb_coalescing_write_buffer_unit;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic        kind;
    logic [31:0] page;
    logic        hit;
    logic        direct;
    logic        last;
  } result_t;

  typedef struct {
    cwb_pkg::opcode_e op;
    logic [31:0]      page;
    logic             fua;
    result_t          want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cwb_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [cwb_pkg::CFG_W-1:0] cfg_data_i = '0;

  cwb_in_if in_ch ();
  cwb_out_if out_ch ();

  coalescing_write_buffer_unit #(.DEPTH(DEPTH), .PAGE_BITS(32)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.page_number = '0;
    in_ch.force_unit_access = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Local copy of the buffer state and registers.
  int unsigned reg_pages, reg_pct, reg_cache;
  logic [31:0] lru_pages[$];  // oldest first
  result_t     pending_results[$];
  int          mismatch_count = 0;
  int          error_count = 0;

  function automatic int unsigned size_now();
    return reg_pages > DEPTH ? DEPTH : reg_pages;
  endfunction

  function automatic int unsigned mark_now();
    int unsigned pct, wm;
    pct = reg_pct > 100 ? 100 : reg_pct;
    wm = size_now() * pct / 100;
    return wm > 0 ? wm : 1;
  endfunction

  function automatic result_t mk(logic k, logic [31:0] p, logic h, logic d, logic l);
    result_t r;
    r.kind = k; r.page = p; r.hit = h; r.direct = d; r.last = l;
    return r;
  endfunction

  function automatic void evict_oldest();
    if (lru_pages.size() > 0)
      pending_results.push_back(mk(cwb_pkg::KIND_EVICT, lru_pages.pop_front(), 0, 0, 0));
  endfunction

  // Applies one request to the local state and queues the results it causes.
  function automatic void predict_buffer(cwb_pkg::opcode_e op, logic [31:0] page, logic fua);
    int idx, b;
    bit on;
    idx = -1;
    foreach (lru_pages[i]) if (lru_pages[i] == page) idx = i;
    on = size_now() > 0 && reg_cache != 0;
    case (op)
      cwb_pkg::OPC_WRITE: begin
        if (on && !fua) begin
          if (idx < 0) begin
            if (lru_pages.size() >= mark_now()) begin
              b = size_now() > mark_now() ? size_now() - mark_now() : 1;
              for (int k = 0; k < b && lru_pages.size() > 0; k++) evict_oldest();
            end
            if (lru_pages.size() >= DEPTH) evict_oldest();
            lru_pages.push_back(page);
            pending_results.push_back(mk(cwb_pkg::KIND_DONE, page, 0, 0, 1));
          end else begin
            lru_pages.delete(idx);
            lru_pages.push_back(page);
            pending_results.push_back(mk(cwb_pkg::KIND_DONE, page, 1, 0, 1));
          end
        end else begin
          if (idx >= 0) lru_pages.delete(idx);
          if (!on) while (lru_pages.size() > 0) evict_oldest();
          pending_results.push_back(mk(cwb_pkg::KIND_DONE, page, 0, 1, 1));
        end
      end
      cwb_pkg::OPC_READ:
        pending_results.push_back(mk(cwb_pkg::KIND_DONE, page, idx >= 0, 0, 1));
      cwb_pkg::OPC_DISCARD: begin
        if (idx >= 0) lru_pages.delete(idx);
        pending_results.push_back(mk(cwb_pkg::KIND_DONE, page, idx >= 0, 0, 1));
      end
      default: begin
        while (lru_pages.size() > 0) evict_oldest();
        pending_results.push_back(mk(cwb_pkg::KIND_DONE, '0, 0, 0, 1));
      end
    endcase
  endfunction

  function automatic void report_bad(string what, result_t want, result_t got);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"mismatch %s: expected k=%0d p=%h h=%0d d=%0d l=%0d",
                " got k=%0d p=%h h=%0d d=%0d l=%0d"},
               what, want.kind, want.page, want.hit, want.direct, want.last,
               got.kind, got.page, got.hit, got.direct, got.last);
  endfunction

  // Result side: stall pattern plus comparison against the oldest expectation.
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = mk(out_ch.kind, out_ch.out_page, out_ch.hit, out_ch.direct, out_ch.last);
      if (pending_results.size() == 0) report_bad("unexpected", '0, got);
      else begin
        want = pending_results.pop_front();
        if (got !== want) report_bad("field", want, got);
      end
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  int burst_left = 0;

  // Valid drops here only at the start of a gap, so it never gets two updates in
  // one time step.
  task automatic send_request(cwb_pkg::opcode_e op, logic [31:0] page, logic fua);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.page_number <= page;
    in_ch.force_unit_access <= fua;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_buffer(op, page, fua);
  endtask

  task automatic write_reg(cwb_pkg::cfg_idx_e idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= cwb_pkg::CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cwb_pkg::CFG_BUFFER_PAGES: reg_pages = value & 6'h3f;
      cwb_pkg::CFG_WATERMARK:    reg_pct = value & 7'h7f;
      default:                   reg_cache = value & 1;
    endcase
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_page(int unsigned pool);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'hA000_0000 + $urandom_range(0, pool);
  endfunction

  row_t rows[$];

  initial begin
    cwb_pkg::opcode_e op;
    reg_pages = 0; reg_pct = 90; reg_cache = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Right after reset the buffer size is zero, so writes go direct.
    rows.push_back('{cwb_pkg::OPC_WRITE, 32'hFFFF_FFFF, 0,
                     mk(cwb_pkg::KIND_DONE, 32'hFFFF_FFFF, 0, 1, 1)});
    rows.push_back('{cwb_pkg::OPC_READ, 32'hFFFF_FFFF, 0,
                     mk(cwb_pkg::KIND_DONE, 32'hFFFF_FFFF, 0, 0, 1)});
    rows.push_back('{cwb_pkg::OPC_DISCARD, 32'h0, 0,
                     mk(cwb_pkg::KIND_DONE, 32'h0, 0, 0, 1)});
    rows.push_back('{cwb_pkg::OPC_FLUSH, 32'h1234_5678, 1,
                     mk(cwb_pkg::KIND_DONE, 32'h0, 0, 0, 1)});
    foreach (rows[i]) begin
      pending_results.push_back(rows[i].want);
      send_request(rows[i].op, rows[i].page, rows[i].fua);
      // The typed result stands in for the predicted completion.
      void'(pending_results.pop_back());
    end
    drain_wait();

    // Small buffer with a 50 percent mark: fills, evicts, coalesces, fua, discard.
    write_reg(cwb_pkg::CFG_BUFFER_PAGES, 4);
    write_reg(cwb_pkg::CFG_WATERMARK, 50);
    write_reg(cwb_pkg::CFG_CACHE_EN, 1);
    for (int i = 0; i < 4; i++) send_request(cwb_pkg::OPC_WRITE, 32'h10 + i, 0);
    send_request(cwb_pkg::OPC_WRITE, 32'h12, 0);
    send_request(cwb_pkg::OPC_READ, 32'h12, 0);
    send_request(cwb_pkg::OPC_WRITE, 32'h12, 1);
    send_request(cwb_pkg::OPC_DISCARD, 32'h13, 0);
    send_request(cwb_pkg::OPC_DISCARD, 32'h13, 0);
    send_request(cwb_pkg::OPC_WRITE, 32'h5555_AAAA, 0);
    send_request(cwb_pkg::OPC_FLUSH, 32'hAAAA_5555, 0);
    drain_wait();
    // Oversized register and percent: both saturate; then shrink while full.
    write_reg(cwb_pkg::CFG_BUFFER_PAGES, 63);
    write_reg(cwb_pkg::CFG_WATERMARK, 127);
    for (int i = 0; i < 34; i++) send_request(cwb_pkg::OPC_WRITE, 32'h100 + i, 0);
    drain_wait();
    write_reg(cwb_pkg::CFG_BUFFER_PAGES, 3);
    write_reg(cwb_pkg::CFG_WATERMARK, 0);
    send_request(cwb_pkg::OPC_WRITE, 32'h900, 0);
    send_request(cwb_pkg::OPC_WRITE, 32'h901, 0);
    drain_wait();
    write_reg(cwb_pkg::CFG_CACHE_EN, 0);
    send_request(cwb_pkg::OPC_WRITE, 32'h101, 0);
    drain_wait();

    // Random phases over a range of settings, extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(cwb_pkg::CFG_BUFFER_PAGES, 32);
          write_reg(cwb_pkg::CFG_WATERMARK, 100);
        end
        1: begin
          write_reg(cwb_pkg::CFG_BUFFER_PAGES, 1);
          write_reg(cwb_pkg::CFG_WATERMARK, 0);
        end
        2: write_reg(cwb_pkg::CFG_BUFFER_PAGES, 0);
        default: begin
          write_reg(cwb_pkg::CFG_BUFFER_PAGES, $urandom_range(0, 63));
          write_reg(cwb_pkg::CFG_WATERMARK, $urandom_range(0, 127));
        end
      endcase
      write_reg(cwb_pkg::CFG_CACHE_EN, (ph == 5) ? 0 : 1);
      for (int i = 0; i < 34; i++) begin
        case ($urandom_range(0, 19))
          0: op = cwb_pkg::OPC_FLUSH;
          1, 2, 3: op = cwb_pkg::OPC_READ;
          4, 5: op = cwb_pkg::OPC_DISCARD;
          default: op = cwb_pkg::OPC_WRITE;
        endcase
        send_request(op, pick_page(24), $urandom_range(0, 9) == 0);
      end
      drain_wait();
    end

    drain_wait();
    if (error_count == 0 && pending_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
